// File: rtl/iala_pkg.sv
// Shared widths, command and status codes, and controller-to-datapath types.
package iala_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 64;

   localparam int unsigned CMD_W    = 3;
   localparam int unsigned POS_W    = 6;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEL_MATCH = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND      = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ      = 3'd5;
   localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd6;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_LOAD,
      DP_APPEND,
      DP_CLEAR,
      DP_WRITE,
      DP_READ,
      DP_UP_INIT,
      DP_UP_STEP,
      DP_UP_FILL,
      DP_SRCH_INIT,
      DP_SRCH_STEP,
      DP_HIT,
      DP_DN_INIT,
      DP_DN_STEP,
      DP_DN_DONE,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      logic [STATUS_W-1:0] status;
      logic                rd_sel;
      logic                fp_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic pos_gt_count;
      logic pos_ge_count;
      logic full;
      logic up_more;
      logic dn_more;
      logic srch_more;
      logic match;
      logic wr_pend;
      logic cmp_pend;
   } dp_stat_type;

endpackage

// File: rtl/iala_if.sv
// Request and response channel interfaces.
interface iala_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [iala_pkg::CMD_W-1:0]    cmd;
   logic        [iala_pkg::POS_W-1:0]    position;
   logic signed [iala_pkg::DATA_W-1:0]   item_value;

   modport source (output valid, cmd, position, item_value, input ready);
   modport sink   (input valid, cmd, position, item_value, output ready);
endinterface

interface iala_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic        [iala_pkg::STATUS_W-1:0] status;
   logic signed [iala_pkg::DATA_W-1:0]   read_data;
   logic        [iala_pkg::POS_W-1:0]    found_position;
   logic        [iala_pkg::COUNT_W-1:0]  element_count;
   logic                                 list_empty;

   modport source (output valid, status, read_data, found_position, element_count, list_empty,
                   input ready);
   modport sink   (input valid, status, read_data, found_position, element_count, list_empty,
                   output ready);
endinterface

// File: rtl/indexed_array_list_unit.sv
// Indexed array list: top level joining the sequencer and the element datapath.
//
// Usage: each request transaction carries a command (append, insert at,
// delete first match, delete at, find, read at, write at, clear), a position
// and a value. Every request yields exactly one response transaction with a
// status, read data, found position, element count and an empty flag.
// Requests are taken one at a time; req_if.ready is high while the unit is
// idle, including while the previous response still waits in its register.
// Append, write, clear and refused commands take the shortest path; read
// also waits for the store read. Insert and delete at move each shifted
// element in turn; find compares the elements in order until a match, or
// all of them when nothing matches; delete-first-match searches and then
// moves. The worst case is a delete-first-match on a full list, set by the
// single read and write port of the element store, which moves or compares
// one element per cycle.
// Reset empties the list; store contents are not cleared. If the receiver
// stalls, the response is held and the unit waits after finishing its next
// command until the response register is free.
module indexed_array_list_unit #(
   parameter int unsigned CAPACITY = iala_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   iala_req_if.sink         req_if,
   iala_rsp_if.source       rsp_if
);

   iala_pkg::dp_cmd_type  dp_cmd;
   iala_pkg::dp_stat_type dp_stat;

   iala_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .req_cmd   (req_if.cmd),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   iala_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_position       (req_if.position),
      .req_item_value     (req_if.item_value),
      .dp_cmd             (dp_cmd),
      .dp_stat            (dp_stat),
      .rsp_status         (rsp_if.status),
      .rsp_read_data      (rsp_if.read_data),
      .rsp_found_position (rsp_if.found_position),
      .rsp_element_count  (rsp_if.element_count),
      .rsp_list_empty     (rsp_if.list_empty)
   );

endmodule

// File: rtl/iala_datapath.sv
// Element store, count, walking index and response registers.
module iala_datapath #(
   parameter int unsigned CAPACITY = iala_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic        [iala_pkg::POS_W-1:0]   req_position,
   input  logic        [iala_pkg::DATA_W-1:0]  req_item_value,
   input  iala_pkg::dp_cmd_type                dp_cmd,
   output iala_pkg::dp_stat_type               dp_stat,
   output logic        [iala_pkg::STATUS_W-1:0] rsp_status,
   output logic        [iala_pkg::DATA_W-1:0]  rsp_read_data,
   output logic        [iala_pkg::POS_W-1:0]   rsp_found_position,
   output logic        [iala_pkg::COUNT_W-1:0] rsp_element_count,
   output logic                                rsp_list_empty
);

   localparam int unsigned ADDR_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W  = (CNT_W > iala_pkg::POS_W) ? CNT_W : iala_pkg::POS_W;
   localparam int unsigned CEXT_W = (CNT_W > iala_pkg::COUNT_W) ? CNT_W : iala_pkg::COUNT_W;
   localparam int unsigned FEXT_W = (ADDR_W > iala_pkg::POS_W) ? ADDR_W : iala_pkg::POS_W;

   logic [iala_pkg::DATA_W-1:0] mem [CAPACITY];

   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic                          pend_ff, pend_in;
   logic [ADDR_W-1:0]             paddr_ff, paddr_in;
   logic                          cmpv_ff, cmpv_in;
   logic [ADDR_W-1:0]             caddr_ff, caddr_in;
   logic [ADDR_W-1:0]             fpos_ff, fpos_in;
   logic [iala_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [iala_pkg::DATA_W-1:0]   val_ff, val_in;
   logic [iala_pkg::DATA_W-1:0]   rdata_ff;

   logic [iala_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [iala_pkg::DATA_W-1:0]   rsp_rdata_ff;
   logic [iala_pkg::POS_W-1:0]    rsp_fpos_ff;
   logic [iala_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic                          rsp_empty_ff;

   logic                          rd_en;
   logic [ADDR_W-1:0]             rd_addr;
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [iala_pkg::DATA_W-1:0]   wr_data;

   logic [CMP_W-1:0]              pos_ext, cnt_cmp, idx_cmp;
   logic [CNT_W-1:0]              idx_inc, idx_dec;
   logic [ADDR_W-1:0]             pos_addr;
   logic [CEXT_W-1:0]             cnt_ext;
   logic [FEXT_W-1:0]             fpos_ext;

   assign pos_ext  = CMP_W'(pos_ff);
   assign cnt_cmp  = CMP_W'(count_ff);
   assign idx_cmp  = CMP_W'(idx_ff);
   assign pos_addr = pos_ext[ADDR_W-1:0];
   assign idx_inc  = idx_ff + CNT_W'(1);
   assign idx_dec  = idx_ff - CNT_W'(1);
   assign cnt_ext  = CEXT_W'(count_ff);
   assign fpos_ext = FEXT_W'(fpos_ff);

   always_comb begin
      dp_stat.pos_gt_count = pos_ext > cnt_cmp;
      dp_stat.pos_ge_count = pos_ext >= cnt_cmp;
      dp_stat.full         = count_ff == CNT_W'(CAPACITY);
      dp_stat.up_more      = idx_cmp > pos_ext;
      dp_stat.dn_more      = idx_inc < count_ff;
      dp_stat.srch_more    = idx_ff < count_ff;
      dp_stat.match        = cmpv_ff && (rdata_ff == val_ff);
      dp_stat.wr_pend      = pend_ff;
      dp_stat.cmp_pend     = cmpv_ff;
   end

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      pend_in  = 1'b0;
      paddr_in = paddr_ff;
      cmpv_in  = 1'b0;
      caddr_in = caddr_ff;
      fpos_in  = fpos_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      // a delayed shift write drains whenever one is outstanding
      wr_en    = pend_ff;
      wr_addr  = paddr_ff;
      wr_data  = rdata_ff;
      unique case (dp_cmd.op)
         iala_pkg::DP_IDLE, iala_pkg::DP_RESULT: begin
         end
         iala_pkg::DP_LOAD: begin
            pos_in = req_position;
            val_in = req_item_value;
         end
         iala_pkg::DP_APPEND: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[ADDR_W-1:0];
            wr_data  = val_ff;
            count_in = count_ff + CNT_W'(1);
         end
         iala_pkg::DP_CLEAR: begin
            count_in = '0;
         end
         iala_pkg::DP_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = pos_addr;
            wr_data = val_ff;
         end
         iala_pkg::DP_READ: begin
            rd_en   = 1'b1;
            rd_addr = pos_addr;
         end
         iala_pkg::DP_UP_INIT: begin
            idx_in = count_ff;
         end
         iala_pkg::DP_UP_STEP: begin
            if (dp_stat.up_more) begin
               rd_en    = 1'b1;
               rd_addr  = idx_dec[ADDR_W-1:0];
               pend_in  = 1'b1;
               paddr_in = idx_ff[ADDR_W-1:0];
               idx_in   = idx_dec;
            end
         end
         iala_pkg::DP_UP_FILL: begin
            wr_en    = 1'b1;
            wr_addr  = pos_addr;
            wr_data  = val_ff;
            count_in = count_ff + CNT_W'(1);
         end
         iala_pkg::DP_SRCH_INIT: begin
            idx_in = '0;
         end
         iala_pkg::DP_SRCH_STEP: begin
            if (dp_stat.srch_more) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[ADDR_W-1:0];
               cmpv_in  = 1'b1;
               caddr_in = idx_ff[ADDR_W-1:0];
               idx_in   = idx_inc;
            end
         end
         iala_pkg::DP_HIT: begin
            fpos_in = caddr_ff;
            idx_in  = CNT_W'(caddr_ff);
         end
         iala_pkg::DP_DN_INIT: begin
            idx_in = pos_ext[CNT_W-1:0];
         end
         iala_pkg::DP_DN_STEP: begin
            if (dp_stat.dn_more) begin
               rd_en    = 1'b1;
               rd_addr  = idx_inc[ADDR_W-1:0];
               pend_in  = 1'b1;
               paddr_in = idx_ff[ADDR_W-1:0];
               idx_in   = idx_inc;
            end
         end
         iala_pkg::DP_DN_DONE: begin
            count_in = count_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
         cmpv_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
         cmpv_ff  <= cmpv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      paddr_ff <= paddr_in;
      caddr_ff <= caddr_in;
      fpos_ff  <= fpos_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == iala_pkg::DP_RESULT) begin
         rsp_status_ff <= dp_cmd.status;
         rsp_rdata_ff  <= dp_cmd.rd_sel ? rdata_ff : '0;
         rsp_fpos_ff   <= dp_cmd.fp_sel ? fpos_ext[iala_pkg::POS_W-1:0] : '0;
         rsp_count_ff  <= cnt_ext[iala_pkg::COUNT_W-1:0];
         rsp_empty_ff  <= count_ff == '0;
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_read_data      = rsp_rdata_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_element_count  = rsp_count_ff;
   assign rsp_list_empty     = rsp_empty_ff;

endmodule

// File: rtl/iala_controller.sv
// Command sequencer: decodes a transaction and steps the datapath through it.
module iala_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [iala_pkg::CMD_W-1:0]       req_cmd,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output iala_pkg::dp_cmd_type             dp_cmd,
   input  iala_pkg::dp_stat_type            dp_stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ_WAIT,
      S_UP_STEP,
      S_SRCH_STEP,
      S_DN_STEP,
      S_RESP
   } state_type;

   state_type                     state_ff, state_in;
   logic [iala_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [iala_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          rd_sel_ff, rd_sel_in;
   logic                          fp_sel_ff, fp_sel_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      status_in    = status_ff;
      rd_sel_in    = rd_sel_ff;
      fp_sel_in    = fp_sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dp_cmd.op     = iala_pkg::DP_IDLE;
      dp_cmd.status = status_ff;
      dp_cmd.rd_sel = rd_sel_ff;
      dp_cmd.fp_sel = fp_sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               status_in = iala_pkg::ST_OK;
               rd_sel_in = 1'b0;
               fp_sel_in = 1'b0;
               dp_cmd.op = iala_pkg::DP_LOAD;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            unique case (cmd_ff)
               iala_pkg::CMD_APPEND: begin
                  if (dp_stat.full) begin
                     status_in = iala_pkg::ST_FULL;
                  end else begin
                     dp_cmd.op = iala_pkg::DP_APPEND;
                  end
               end
               iala_pkg::CMD_INSERT: begin
                  if (dp_stat.pos_gt_count) begin
                     status_in = iala_pkg::ST_RANGE;
                  end else if (dp_stat.full) begin
                     status_in = iala_pkg::ST_FULL;
                  end else begin
                     dp_cmd.op = iala_pkg::DP_UP_INIT;
                     state_in  = S_UP_STEP;
                  end
               end
               iala_pkg::CMD_DEL_MATCH, iala_pkg::CMD_FIND: begin
                  dp_cmd.op = iala_pkg::DP_SRCH_INIT;
                  state_in  = S_SRCH_STEP;
               end
               iala_pkg::CMD_DEL_AT: begin
                  if (dp_stat.pos_ge_count) begin
                     status_in = iala_pkg::ST_RANGE;
                  end else begin
                     dp_cmd.op = iala_pkg::DP_DN_INIT;
                     state_in  = S_DN_STEP;
                  end
               end
               iala_pkg::CMD_READ: begin
                  if (dp_stat.pos_ge_count) begin
                     status_in = iala_pkg::ST_RANGE;
                  end else begin
                     dp_cmd.op = iala_pkg::DP_READ;
                     state_in  = S_READ_WAIT;
                  end
               end
               iala_pkg::CMD_WRITE: begin
                  if (dp_stat.pos_ge_count) begin
                     status_in = iala_pkg::ST_RANGE;
                  end else begin
                     dp_cmd.op = iala_pkg::DP_WRITE;
                  end
               end
               default: begin
                  // clear
                  dp_cmd.op = iala_pkg::DP_CLEAR;
               end
            endcase
         end
         S_READ_WAIT: begin
            rd_sel_in = 1'b1;
            state_in  = S_RESP;
         end
         S_UP_STEP: begin
            if (!dp_stat.up_more && !dp_stat.wr_pend) begin
               dp_cmd.op = iala_pkg::DP_UP_FILL;
               state_in  = S_RESP;
            end else begin
               dp_cmd.op = iala_pkg::DP_UP_STEP;
            end
         end
         S_SRCH_STEP: begin
            priority if (dp_stat.match) begin
               dp_cmd.op = iala_pkg::DP_HIT;
               if (cmd_ff == iala_pkg::CMD_FIND) begin
                  fp_sel_in = 1'b1;
                  state_in  = S_RESP;
               end else begin
                  state_in  = S_DN_STEP;
               end
            end else if (!dp_stat.srch_more && !dp_stat.cmp_pend) begin
               status_in = iala_pkg::ST_NOTFOUND;
               state_in  = S_RESP;
            end else begin
               dp_cmd.op = iala_pkg::DP_SRCH_STEP;
            end
         end
         S_DN_STEP: begin
            if (!dp_stat.dn_more && !dp_stat.wr_pend) begin
               dp_cmd.op = iala_pkg::DP_DN_DONE;
               state_in  = S_RESP;
            end else begin
               dp_cmd.op = iala_pkg::DP_DN_STEP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.op    = iala_pkg::DP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmd_ff       <= iala_pkg::CMD_APPEND;
         status_ff    <= iala_pkg::ST_OK;
         rd_sel_ff    <= 1'b0;
         fp_sel_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         status_ff    <= status_in;
         rd_sel_ff    <= rd_sel_in;
         fp_sel_ff    <= fp_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule
